/* hdl/pftfn_pkg.sv */
// ----------------------------------------------------------------------------
// pftfn_pkg: shared types and constants for the fan triangulator
// Holds the sequencer state type, the cross product term table and defaults.
// ----------------------------------------------------------------------------
package pftfn_pkg;

    localparam int POINT_DEPTH_DEF = 4096;
    localparam int FAN_VERTS       = 3;
    localparam int CROSS_TERMS     = 6;
    localparam int SQRT_STEPS      = 32;
    localparam int DIV_STEPS       = 16;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_FAN,
        ST_CROSS_MUL,
        ST_CROSS_ACC,
        ST_SCALE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0] ia;
        logic [2:0] ib;
        logic       sub;
    } cross_term_t;

    // Term k of the cross product; terms 2j and 2j+1 build component j.
    function automatic cross_term_t cross_term(input logic [2:0] k);
        cross_term_t t;
        unique case (k)
            3'd0:    t = '{ia: 3'd1, ib: 3'd5, sub: 1'b0};
            3'd1:    t = '{ia: 3'd2, ib: 3'd4, sub: 1'b1};
            3'd2:    t = '{ia: 3'd2, ib: 3'd3, sub: 1'b0};
            3'd3:    t = '{ia: 3'd0, ib: 3'd5, sub: 1'b1};
            3'd4:    t = '{ia: 3'd0, ib: 3'd4, sub: 1'b0};
            3'd5:    t = '{ia: 3'd1, ib: 3'd3, sub: 1'b1};
            default: t = '{ia: 3'd0, ib: 3'd0, sub: 1'b0};
        endcase
        return t;
    endfunction

endpackage

/* hdl/pftfn_in_if.sv */
// ----------------------------------------------------------------------------
// pftfn_in_if: input channel of the fan triangulator
// Carries one load or vertex word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pftfn_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic        [11:0] point_addr;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [12:0] poly_index;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;

    modport source (output valid, cmd, point_addr, coord_x, coord_y, coord_z,
                    poly_index, tex_u, tex_v, input ready);
    modport sink   (input valid, cmd, point_addr, coord_x, coord_y, coord_z,
                    poly_index, tex_u, tex_v, output ready);
endinterface

/* hdl/pftfn_out_if.sv */
// ----------------------------------------------------------------------------
// pftfn_out_if: output channel of the fan triangulator
// Carries one triangle vertex word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pftfn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_of_triangle;

    modport source (output valid, pos_x, pos_y, pos_z, out_u, out_v, normal_x,
                    normal_y, normal_z, last_of_triangle, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, out_u, out_v, normal_x,
                    normal_y, normal_z, last_of_triangle, output ready);
endinterface

/* hdl/polygon_fan_triangulator_flat_normals_core.sv */
// ----------------------------------------------------------------------------
// polygon_fan_triangulator_flat_normals_core: fan triangulator with normals
// Loads a point table, splits streamed polygons into fans and emits each
// triangle as three vertex words that carry the flat unit face normal.
// ----------------------------------------------------------------------------
// The block takes one word at a time and is not ready while it works on it.
// A load word writes the point table once its address has been folded back
// into the table depth as often as needed. A vertex word that does not close
// a triangle reads its point into the fan. A vertex word that closes a
// triangle runs the whole normal sequence on one shared 32 by 32 multiplier
// and one wide add and compare unit: cross product, range scaling, squaring,
// square root and three divisions, and only then comes the first output word.
// A degenerate triangle skips the square root and the divisions. The three
// output words follow, each held until the sink takes it. Addresses fold
// modulo POINT_DEPTH; the table has no clearing pass, and a read of a point
// that was never loaded gives whatever the memory holds.
module polygon_fan_triangulator_flat_normals_core
    import pftfn_pkg::*;
#(
    parameter int POINT_DEPTH = POINT_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pftfn_in_if.sink     in_ch,
    pftfn_out_if.source  out_ch
);
    localparam int AW = $clog2(POINT_DEPTH);
    localparam logic [16:0] DEPTH_W = 17'(POINT_DEPTH);

    state_t state_reg, state_next;

    logic               cmd_reg, cmd_next;
    logic        [11:0] addr_reg, addr_next;
    logic               last_reg, last_next;
    logic signed [31:0] coord_reg [3];
    logic signed [31:0] coord_next [3];
    logic signed [31:0] uv_reg [2];
    logic signed [31:0] uv_next [2];
    logic         [1:0] vcount_reg, vcount_next;
    logic signed [31:0] first_pos_reg [3];
    logic signed [31:0] first_pos_next [3];
    logic signed [31:0] first_uv_reg [2];
    logic signed [31:0] first_uv_next [2];
    logic signed [31:0] prev_pos_reg [3];
    logic signed [31:0] prev_pos_next [3];
    logic signed [31:0] prev_uv_reg [2];
    logic signed [31:0] prev_uv_next [2];
    logic signed [31:0] cur_pos_reg [3];
    logic signed [31:0] cur_pos_next [3];
    logic signed [31:0] edge_reg [6];
    logic signed [31:0] edge_next [6];
    logic signed [63:0] cross_reg [3];
    logic signed [63:0] cross_next [3];
    logic signed [63:0] prod_reg, prod_next;
    logic         [2:0] step_reg, step_next;
    logic         [4:0] cnt_reg, cnt_next;
    logic        [63:0] sum_reg, sum_next;
    logic        [63:0] root_reg, root_next;
    logic        [48:0] num_reg, num_next;
    logic        [15:0] quo_reg, quo_next;
    logic signed [15:0] normal_reg [3];
    logic signed [15:0] normal_next [3];

    // Point table.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [95:0]   ram_wdata;
    logic [95:0]   ram_rdata;

    pftfn_ram #(
        .WIDTH (96),
        .DEPTH (POINT_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The shared multiplier, operands chosen by the sequencer.
    cross_term_t        term;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic               addr_big;
    logic        [63:0] sq_bit;
    logic        [63:0] sq_trial;
    logic        [48:0] div_trial;
    logic        [31:0] mag;
    logic signed [31:0] comp32;
    logic signed [32:0] ed [6];
    logic               fit0;
    logic               fit1;
    logic               cross_fits;

    assign term     = cross_term(step_reg);
    assign mul_p    = mul_a * mul_b;
    assign addr_big = {5'd0, addr_reg} >= DEPTH_W;
    assign ram_addr = AW'(addr_reg);
    assign ram_wdata = {coord_reg[0], coord_reg[1], coord_reg[2]};
    assign sq_bit   = 64'(1) << (7'd62 - {1'b0, cnt_reg, 1'b0});
    assign sq_trial = root_reg + sq_bit;
    assign div_trial = {16'd0, root_reg[31:0], 1'b0} << cnt_reg[3:0];
    assign comp32   = cross_reg[step_reg[1:0]][31:0];
    assign mag      = comp32[31] ? (~comp32 + 32'd1) : comp32;

    always_comb
    begin
        mul_a = edge_reg[term.ia];
        mul_b = edge_reg[term.ib];
        if (state_reg == ST_SQ_MUL)
        begin
            mul_a = comp32;
            mul_b = comp32;
        end
    end

    // Edges and the common pre-shift that brings them into 31 bits.
    always_comb
    begin
        fit0 = 1'b1;
        fit1 = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            ed[i]     = 33'(prev_pos_reg[i]) - 33'(first_pos_reg[i]);
            ed[i + 3] = 33'(signed'(ram_rdata[95 - 32*i -: 32])) - 33'(first_pos_reg[i]);
        end
        for (int i = 0; i < 6; i++)
        begin
            if (ed[i][32:30] != 3'b000 && ed[i][32:30] != 3'b111)
            begin
                fit0 = 1'b0;
            end
            if (ed[i][32] != ed[i][31])
            begin
                fit1 = 1'b0;
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            edge_next[i] = fit0 ? ed[i][31:0]
                                : (fit1 ? ed[i][32:1] : {ed[i][32], ed[i][32:2]});
        end
    end

    always_comb
    begin
        cross_fits = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (cross_reg[i][63:31] != {33{1'b0}} && cross_reg[i][63:31] != {33{1'b1}})
            begin
                cross_fits = 1'b0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!addr_big)
                begin
                    state_next = (cmd_reg == CMD_LOAD) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:      state_next = ST_FAN;
            ST_FAN:       state_next = (vcount_reg == 2'd2) ? ST_CROSS_MUL : ST_IDLE;
            ST_CROSS_MUL: state_next = ST_CROSS_ACC;
            ST_CROSS_ACC:
            begin
                state_next = (step_reg == 3'(CROSS_TERMS - 1)) ? ST_SCALE : ST_CROSS_MUL;
            end
            ST_SCALE:
            begin
                if (cross_fits)
                begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:    state_next = ST_SQ_ACC;
            ST_SQ_ACC:
            begin
                if (step_reg != 3'(FAN_VERTS - 1))
                begin
                    state_next = ST_SQ_MUL;
                end
                else if (sum_reg + prod_reg == 64'd0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = (step_reg == 3'(FAN_VERTS - 1)) ? ST_EMIT : ST_DIV_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready && step_reg == 3'(FAN_VERTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        coord_next     = coord_reg;
        uv_next        = uv_reg;
        vcount_next    = vcount_reg;
        first_pos_next = first_pos_reg;
        first_uv_next  = first_uv_reg;
        prev_pos_next  = prev_pos_reg;
        prev_uv_next   = prev_uv_reg;
        cur_pos_next   = cur_pos_reg;
        cross_next     = cross_reg;
        prod_next      = prod_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        root_next      = root_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        normal_next    = normal_reg;
        ram_we         = 1'b0;
        in_ch.ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                cmd_next    = in_ch.cmd;
                coord_next  = '{in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
                uv_next     = '{in_ch.tex_u, in_ch.tex_v};
                // A negative index -(i)-1 names point i and closes the polygon.
                last_next   = in_ch.poly_index[12];
                if (in_ch.cmd == CMD_LOAD)
                begin
                    addr_next = in_ch.point_addr;
                end
                else
                begin
                    addr_next = in_ch.poly_index[12] ? ~in_ch.poly_index[11:0]
                                                     : in_ch.poly_index[11:0];
                end
            end
            ST_REDUCE:
            begin
                if (addr_big)
                begin
                    addr_next = addr_reg - 12'(POINT_DEPTH);
                end
                else if (cmd_reg == CMD_LOAD)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_READ:
            begin
            end
            ST_FAN:
            begin
                unique case (vcount_reg)
                    2'd0:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            first_pos_next[i] = ram_rdata[95 - 32*i -: 32];
                        end
                        first_uv_next = uv_reg;
                        vcount_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            prev_pos_next[i] = ram_rdata[95 - 32*i -: 32];
                        end
                        prev_uv_next = uv_reg;
                        vcount_next  = 2'd2;
                    end
                    default:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            cur_pos_next[i] = ram_rdata[95 - 32*i -: 32];
                            cross_next[i]   = '0;
                        end
                        step_next = 3'd0;
                    end
                endcase
                if (last_reg)
                begin
                    vcount_next = 2'd0;
                end
            end
            ST_CROSS_MUL:
            begin
                prod_next = mul_p;
            end
            ST_CROSS_ACC:
            begin
                cross_next[step_reg[2:1]] = term.sub ? cross_reg[step_reg[2:1]] - prod_reg
                                                     : cross_reg[step_reg[2:1]] + prod_reg;
                step_next = (step_reg == 3'(CROSS_TERMS - 1)) ? 3'd0 : step_reg + 3'd1;
                sum_next  = '0;
            end
            ST_SCALE:
            begin
                if (!cross_fits)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cross_next[i] = cross_reg[i] >>> 1;
                    end
                end
            end
            ST_SQ_MUL:
            begin
                prod_next = mul_p;
            end
            ST_SQ_ACC:
            begin
                sum_next = sum_reg + prod_reg;
                if (step_reg == 3'(FAN_VERTS - 1))
                begin
                    step_next = 3'd0;
                    cnt_next  = 5'd0;
                    root_next = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        normal_next[i] = '0;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SQRT:
            begin
                // One result bit of the integer square root per cycle.
                if (sum_reg >= sq_trial)
                begin
                    sum_next  = sum_reg - sq_trial;
                    root_next = (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_DIV_LOAD:
            begin
                // Rounded quotient: (mag * 2^15 + L) / (2 * L).
                num_next = {2'b00, mag, 15'd0} + 49'(root_reg[31:0]);
                quo_next = '0;
                cnt_next = 5'(DIV_STEPS - 1);
            end
            ST_DIV:
            begin
                if (num_reg >= div_trial)
                begin
                    num_next = num_reg - div_trial;
                    quo_next[cnt_reg[3:0]] = 1'b1;
                end
                if (cnt_reg == 5'd0)
                begin
                    normal_next[step_reg[1:0]] = comp32[31] ? -quo_next : quo_next;
                    step_next = (step_reg == 3'(FAN_VERTS - 1)) ? 3'd0 : step_reg + 3'd1;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (step_reg == 3'(FAN_VERTS - 1))
                    begin
                        prev_pos_next = cur_pos_reg;
                        prev_uv_next  = uv_reg;
                        step_next     = 3'd0;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output word: first, previous, then current vertex of the triangle.
    always_comb
    begin
        out_ch.valid            = (state_reg == ST_EMIT);
        out_ch.last_of_triangle = (step_reg == 3'(FAN_VERTS - 1));
        out_ch.normal_x         = normal_reg[0];
        out_ch.normal_y         = normal_reg[1];
        out_ch.normal_z         = normal_reg[2];
        unique case (step_reg)
            3'd0:
            begin
                out_ch.pos_x = first_pos_reg[0];
                out_ch.pos_y = first_pos_reg[1];
                out_ch.pos_z = first_pos_reg[2];
                out_ch.out_u = first_uv_reg[0];
                out_ch.out_v = first_uv_reg[1];
            end
            3'd1:
            begin
                out_ch.pos_x = prev_pos_reg[0];
                out_ch.pos_y = prev_pos_reg[1];
                out_ch.pos_z = prev_pos_reg[2];
                out_ch.out_u = prev_uv_reg[0];
                out_ch.out_v = prev_uv_reg[1];
            end
            default:
            begin
                out_ch.pos_x = cur_pos_reg[0];
                out_ch.pos_y = cur_pos_reg[1];
                out_ch.pos_z = cur_pos_reg[2];
                out_ch.out_u = uv_reg[0];
                out_ch.out_v = uv_reg[1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vcount_reg <= 2'd0;
            step_reg   <= 3'd0;
            cnt_reg    <= 5'd0;
        end
        else
        begin
            state_reg  <= state_next;
            vcount_reg <= vcount_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        last_reg      <= last_next;
        coord_reg     <= coord_next;
        uv_reg        <= uv_next;
        first_pos_reg <= first_pos_next;
        first_uv_reg  <= first_uv_next;
        prev_pos_reg  <= prev_pos_next;
        prev_uv_reg   <= prev_uv_next;
        cur_pos_reg   <= cur_pos_next;
        edge_reg      <= (state_reg == ST_FAN) ? edge_next : edge_reg;
        cross_reg     <= cross_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        root_reg      <= root_next;
        num_reg       <= num_next;
        quo_reg       <= quo_next;
        normal_reg    <= normal_next;
    end

    // The block never takes a new word while a triangle word is on offer.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while an output word is pending");

    // A triangle ends with its third word and no fourth word follows.
    a_tri_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_of_triangle) |=> !out_ch.valid)
        else $error("output word after the end of a triangle");

    // The x and z normal components stay within one unit.
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.normal_x <= 16'sd16384 && out_ch.normal_x >= -16'sd16384
                       && out_ch.normal_z <= 16'sd16384 && out_ch.normal_z >= -16'sd16384))
        else $error("normal component out of range");

    // The fan count saturates at two vertices.
    a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg != 2'd3)
        else $error("fan vertex count overflow");
endmodule

/* hdl/pftfn_ram.sv */
// ----------------------------------------------------------------------------
// pftfn_ram: generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module pftfn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the polygon fan triangulator
// Loads points into the table, streams polygons of random shape and checks
// every emitted triangle vertex against a predictor of the fan and the face
// normal, under several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import pftfn_pkg::*;

    // Clock and reset. The period is 20 units and reset is held low at the start.
    logic clk;
    logic rst_n;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pftfn_in_if  in_ch ();
    pftfn_out_if out_ch ();

    polygon_fan_triangulator_flat_normals_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // One input word as the source presents it.
    typedef struct {
        logic               cmd;
        logic        [11:0] point_addr;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [12:0] poly_index;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } in_word_t;

    // One triangle vertex as the block should emit it.
    typedef struct {
        longint pos[3];
        longint uv[2];
        longint nrm[3];
        longint last;
    } tri_vert_t;

    localparam int TABLE_DEPTH = POINT_DEPTH_DEF;
    localparam int WATCHDOG    = 20000;
    localparam int HOLD_CYCLES = 400;

    // The scoreboard keeps its own copy of the point table and of the fan,
    // works out the three vertices of each closed triangle when a word is
    // accepted, and compares the vertices the block sends in order.
    class fan_scoreboard;
        longint    points[TABLE_DEPTH][3];
        longint    first_pos[3];
        longint    prev_pos[3];
        longint    first_uv[2];
        longint    prev_uv[2];
        int        fan_len;
        tri_vert_t pending[$];
        int        errors;

        function new();
            fan_len = 0;
            errors  = 0;
            foreach (first_pos[i])
            begin
                first_pos[i] = 0;
                prev_pos[i]  = 0;
            end
            foreach (first_uv[i])
            begin
                first_uv[i] = 0;
                prev_uv[i]  = 0;
            end
        endfunction

        // True when every one of the first cnt values, shifted right by sh with
        // floor, lies between lo and hi.
        function bit in_range(longint v[6], int cnt, int sh, longint lo, longint hi);
            longint x;
            for (int i = 0; i < cnt; i++)
            begin
                x = v[i] >>> sh;
                if (x < lo || x > hi)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function longint root_floor(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // Unit normal of the triangle p0, p1, p2 in Q2.14.
        function void face_normal(longint p0[3], longint p1[3], longint p2[3],
                                  output longint n[3]);
            longint    e[6];
            longint    c[6];
            int        s;
            int        t;
            bit [63:0] sum;
            longint    len;
            longint    mag;
            longint    q;
            for (int i = 0; i < 3; i++)
            begin
                e[i]     = p1[i] - p0[i];
                e[3 + i] = p2[i] - p0[i];
            end
            s = 0;
            while (s < 2 && !in_range(e, 6, s, -(64'sd1 <<< 30), (64'sd1 <<< 30) - 1))
                s++;
            foreach (e[i])
                e[i] = e[i] >>> s;
            c[0] = e[1] * e[5] - e[2] * e[4];
            c[1] = e[2] * e[3] - e[0] * e[5];
            c[2] = e[0] * e[4] - e[1] * e[3];
            c[3] = 0;
            c[4] = 0;
            c[5] = 0;
            t = 0;
            while (t < 40 && !in_range(c, 3, t, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1))
                t++;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                c[i] = c[i] >>> t;
                sum  = sum + 64'(c[i] * c[i]);
            end
            if (sum == 0)
            begin
                n[0] = 0;
                n[1] = 0;
                n[2] = 0;
                return;
            end
            len = root_floor(sum);
            for (int i = 0; i < 3; i++)
            begin
                mag  = (c[i] < 0) ? -c[i] : c[i];
                q    = (mag * 32768 + len) / (2 * len);
                n[i] = (c[i] < 0) ? -q : q;
            end
        endfunction

        // Called for each word the block accepts.
        function void note_word(in_word_t w);
            longint    idx;
            bit        closes;
            longint    p[3];
            longint    uv[2];
            longint    n[3];
            tri_vert_t tv;
            if (w.cmd == CMD_LOAD)
            begin
                points[w.point_addr % TABLE_DEPTH][0] = w.coord_x;
                points[w.point_addr % TABLE_DEPTH][1] = w.coord_y;
                points[w.point_addr % TABLE_DEPTH][2] = w.coord_z;
                return;
            end
            idx    = w.poly_index;
            closes = idx < 0;
            if (closes)
                idx = -idx - 1;
            for (int i = 0; i < 3; i++)
                p[i] = points[idx % TABLE_DEPTH][i];
            uv[0] = w.tex_u;
            uv[1] = w.tex_v;
            if (fan_len == 0)
            begin
                first_pos = p;
                first_uv  = uv;
                fan_len   = 1;
            end
            else if (fan_len == 1)
            begin
                prev_pos = p;
                prev_uv  = uv;
                fan_len  = 2;
            end
            else
            begin
                face_normal(first_pos, prev_pos, p, n);
                tv.nrm  = n;
                tv.last = 0;
                tv.pos  = first_pos;
                tv.uv   = first_uv;
                pending = {pending, tv};
                tv.pos  = prev_pos;
                tv.uv   = prev_uv;
                pending = {pending, tv};
                tv.pos  = p;
                tv.uv   = uv;
                tv.last = 1;
                pending = {pending, tv};
                prev_pos = p;
                prev_uv  = uv;
            end
            if (closes)
                fan_len = 0;
        endfunction

        function void cmp(string field, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // Called for each vertex word the block sends.
        function void check_vertex(longint px, longint py, longint pz, longint u,
                                   longint v, longint nx, longint ny, longint nz,
                                   longint last);
            tri_vert_t tv;
            if (pending.size() == 0)
            begin
                $error("vertex word with no vertex outstanding");
                errors++;
                return;
            end
            tv = pending.pop_front();
            cmp("pos_x", tv.pos[0], px);
            cmp("pos_y", tv.pos[1], py);
            cmp("pos_z", tv.pos[2], pz);
            cmp("out_u", tv.uv[0], u);
            cmp("out_v", tv.uv[1], v);
            cmp("normal_x", tv.nrm[0], nx);
            cmp("normal_y", tv.nrm[1], ny);
            cmp("normal_z", tv.nrm[2], nz);
            cmp("last_of_triangle", tv.last, last);
        endfunction
    endclass

    fan_scoreboard sb;

    // Idling controls shared by the source task and the sink process.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_asked;
    int hold_given;
    int hold_left;
    int quiet_cycles;
    int sent_words;

    // Addresses loaded so far; vertex words only name these.
    int loaded[$];
    bit is_loaded[TABLE_DEPTH];

    // The monitor samples both channels at the edge, before the block's own
    // updates land, feeds the scoreboard and runs the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_word('{in_ch.cmd, in_ch.point_addr, in_ch.coord_x,
                               in_ch.coord_y, in_ch.coord_z, in_ch.poly_index,
                               in_ch.tex_u, in_ch.tex_v});
            end
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_vertex(out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                                out_ch.out_u, out_ch.out_v, out_ch.normal_x,
                                out_ch.normal_y, out_ch.normal_z,
                                out_ch.last_of_triangle);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // The sink. A long hold-off, when asked for, is counted here; otherwise
    // ready follows the stall percentage of the current phase.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_given != hold_asked)
        begin
            hold_given = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Presents one word and holds it until the block takes it, then idles
    // the source for a random spell if the phase asks for it.
    task automatic send_word(in_word_t w);
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= w.cmd;
        in_ch.point_addr <= w.point_addr;
        in_ch.coord_x    <= w.coord_x;
        in_ch.coord_y    <= w.coord_y;
        in_ch.coord_z    <= w.coord_z;
        in_ch.poly_index <= w.poly_index;
        in_ch.tex_u      <= w.tex_u;
        in_ch.tex_v      <= w.tex_v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_words++;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    function automatic in_word_t noise_word();
        in_word_t w;
        w.cmd        = CMD_LOAD;
        w.point_addr = 12'($urandom);
        w.coord_x    = $urandom;
        w.coord_y    = $urandom;
        w.coord_z    = $urandom;
        w.poly_index = 13'($urandom);
        w.tex_u      = $urandom;
        w.tex_v      = $urandom;
        return w;
    endfunction

    // A coordinate: mostly moderate, sometimes full range or an extreme.
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        endcase
    endfunction

    task automatic load_point(int addr, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        in_word_t w;
        w            = noise_word();
        w.point_addr = 12'(addr);
        w.coord_x    = x;
        w.coord_y    = y;
        w.coord_z    = z;
        send_word(w);
        if (!is_loaded[addr])
        begin
            is_loaded[addr] = 1'b1;
            loaded = {loaded, addr};
        end
    endtask

    // A vertex word naming point idx; closing words use the negative form.
    task automatic send_vertex(int idx, bit closes);
        in_word_t w;
        w            = noise_word();
        w.cmd        = CMD_VERTEX;
        w.poly_index = 13'(closes ? -idx - 1 : idx);
        w.tex_u      = $urandom;
        w.tex_v      = $urandom;
        send_word(w);
    endtask

    function automatic int any_loaded();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    // One random polygon. Most are well formed with three to seven vertices;
    // some are short, some carry a load in the middle, some repeat a point.
    task automatic random_polygon();
        int nv;
        int pt;
        nv = $urandom_range(3, 7);
        if ($urandom_range(0, 9) == 0)
            nv = $urandom_range(1, 2);
        pt = any_loaded();
        for (int i = 0; i < nv; i++)
        begin
            if ($urandom_range(0, 5) != 0)
                pt = any_loaded();
            send_vertex(pt, i == nv - 1);
            if ($urandom_range(0, 11) == 0)
                load_point($urandom_range(0, TABLE_DEPTH - 1), pick_coord(),
                           pick_coord(), pick_coord());
        end
    endtask

    // Stops offering words and waits until every expected vertex has come.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int words);
        int target;
        target = sent_words + words;
        while (sent_words < target)
            random_polygon();
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked     = 0;
        hold_given     = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        sent_words     = 0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_LOAD;
        in_ch.point_addr = '0;
        in_ch.coord_x    = '0;
        in_ch.coord_y    = '0;
        in_ch.coord_z    = '0;
        in_ch.poly_index = '0;
        in_ch.tex_u      = '0;
        in_ch.tex_v      = '0;
        out_ch.ready     = 1'b0;
        clk              = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Points at both ends of the table hold the coordinate
        // extremes; a point far from the others forces the edge scaling.
        load_point(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        load_point(TABLE_DEPTH - 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        load_point(1, 0, 0, 0);
        load_point(2, 32'sh0001_0000, 0, 0);
        load_point(3, 0, 32'sh0001_0000, 0);
        load_point(4, 32'sh0002_0000, 0, 0);
        // A plain unit triangle whose normal lies on the z axis.
        send_vertex(1, 0);
        send_vertex(2, 0);
        send_vertex(3, 1);
        // Collinear points give a zero normal.
        send_vertex(1, 0);
        send_vertex(2, 0);
        send_vertex(4, 1);
        // Short polygons of one and two vertices emit nothing.
        send_vertex(2, 1);
        send_vertex(3, 0);
        send_vertex(4, 1);
        // A quad across the extreme points, with a load in the middle of it.
        send_vertex(0, 0);
        send_vertex(TABLE_DEPTH - 1, 0);
        load_point(5, 32'sh1234_5678, 32'shEDCB_A987, 32'sh0000_0001);
        send_vertex(1, 0);
        send_vertex(TABLE_DEPTH - 1, 1);
        wait_drained();

        // Fill the table at random addresses before the random part.
        for (int i = 0; i < 40; i++)
            load_point($urandom_range(0, TABLE_DEPTH - 1), pick_coord(),
                       pick_coord(), pick_coord());

        random_phase(60);

        send_idle_pct  = 66;
        recv_stall_pct = 0;
        random_phase(60);

        // The sink holds off for a long stretch while the source keeps going,
        // so the block fills and stops taking words.
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        hold_asked++;
        random_phase(60);

        // The source pauses until every vertex has come out.
        wait_drained();

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        random_phase(60);

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
hdl/pftfn_pkg.sv
hdl/pftfn_in_if.sv
hdl/pftfn_out_if.sv
hdl/pftfn_ram.sv
hdl/polygon_fan_triangulator_flat_normals_core.sv
verif/tb_top.sv
